/* rtl/swipe_gesture_recognizer_top_macros.svh */
// Assertion macros used by the recognizer top module.
`ifndef SWIPE_GESTURE_RECOGNIZER_TOP_MACROS_SVH
`define SWIPE_GESTURE_RECOGNIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swipe gesture recognizer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swipe gesture recognizer: assertion failed");

`else

`define SGR_ASSERT_SAME(label, clk, rst, ante, cons)
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/sgr_pkg.sv */
package sgr_pkg;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A_DIRS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A_LEN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B_DIRS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B_LEN  = 3'd4;

  localparam int THRESHOLD_W = 12;
  localparam int THR_SQ_W    = 2 * THRESHOLD_W;
  localparam int PATTERN_W   = 16;
  localparam int PAT_LEN_W   = 4;
  localparam int PATTERN_MAX = 8;
  localparam int STROKE_W    = 4;

  localparam logic [THRESHOLD_W-1:0] MOVE_THRESHOLD_RESET = 12'd10;
  localparam logic [THR_SQ_W-1:0]    THR_SQ_RESET         = 24'd100;
  localparam logic [PATTERN_W-1:0]   PATTERN_A_DIRS_RESET = 16'd14;
  localparam logic [PAT_LEN_W-1:0]   PATTERN_A_LEN_RESET  = 4'd2;
  localparam logic [PATTERN_W-1:0]   PATTERN_B_DIRS_RESET = 16'd11;
  localparam logic [PAT_LEN_W-1:0]   PATTERN_B_LEN_RESET  = 4'd2;

endpackage

/* rtl/swipe_gesture_recognizer_top.sv */
// Swipe gesture recognizer. Each input transfer is one touchpad sample and
// yields exactly one result transfer carrying the latched gesture status and
// the current stroke length. Samples are taken one per clock cycle while the
// result side keeps up. Each sample is registered first; then a single
// compute stage updates the anchor, the stroke and the match status together
// and loads the result register, and a stall on the result side can hold the
// sample between the two. One sample and one finished result can wait at the
// same time. The squared movement threshold is computed when move_threshold is
// written and is used from the next cycle on.
`include "swipe_gesture_recognizer_top_macros.svh"

module swipe_gesture_recognizer_top #(
  parameter int MAX_DIRS   = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               touching,
  input  logic [COORD_BITS-1:0]              pos_x,
  input  logic [COORD_BITS-1:0]              pos_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               gesture_found,
  output logic                               gesture_index,
  output logic [sgr_pkg::STROKE_W-1:0]       stroke_length
);
  import sgr_pkg::*;

  localparam int CW    = $clog2(MAX_DIRS + 1);
  localparam int IW    = $clog2(MAX_DIRS);
  localparam int LW    = (CW > PAT_LEN_W) ? CW : PAT_LEN_W;
  localparam int CMP_N = (MAX_DIRS < PATTERN_MAX) ? MAX_DIRS : PATTERN_MAX;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int DW    = (SQ_W + 1 > THR_SQ_W) ? SQ_W + 1 : THR_SQ_W;

  logic [THRESHOLD_W-1:0] thr_wr;
  logic [THR_SQ_W-1:0]    thr_sq;
  logic [PATTERN_W-1:0]   pat_a_dirs;
  logic [PAT_LEN_W-1:0]   pat_a_len;
  logic [PATTERN_W-1:0]   pat_b_dirs;
  logic [PAT_LEN_W-1:0]   pat_b_len;

  logic                  s1_valid;
  logic                  s1_touch;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;

  logic [COORD_BITS-1:0]      anchor_x;
  logic [COORD_BITS-1:0]      anchor_y;
  logic                       anchor_valid;
  logic [MAX_DIRS-1:0][1:0]   dir_store;
  logic [1:0]                 last_dir;
  logic [CW-1:0]              dir_count;
  logic                       dir_overflow;
  logic                       found_reg;
  logic                       index_reg;

  logic                       advance;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic [SQ_W-1:0]            sq_x;
  logic [SQ_W-1:0]            sq_y;
  logic [DW-1:0]              dist_sq;
  logic                       moved;
  logic [1:0]                 new_dir;
  logic                       match_a;
  logic                       match_b;

  logic                       anchor_valid_next;
  logic                       anchor_load;
  logic                       dir_store_write;
  logic [CW-1:0]              dir_count_next;
  logic                       dir_overflow_next;
  logic                       found_reg_next;
  logic                       index_reg_next;

  function automatic logic stroke_match(
    input logic [PATTERN_W-1:0]      dirs,
    input logic [PAT_LEN_W-1:0]      len,
    input logic [MAX_DIRS-1:0][1:0]  stored,
    input logic [CW-1:0]             count,
    input logic                      overflow
  );
    logic ok;
    ok = !overflow && (LW'(len) == LW'(count)) && (int'(len) <= PATTERN_MAX)
         && (int'(len) <= MAX_DIRS);
    for (int i = 0; i < CMP_N; i++) begin
      if ((i < int'(len)) && (dirs[2*i +: 2] != stored[i])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign thr_wr = cfg_data[THRESHOLD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq     <= THR_SQ_RESET;
      pat_a_dirs <= PATTERN_A_DIRS_RESET;
      pat_a_len  <= PATTERN_A_LEN_RESET;
      pat_b_dirs <= PATTERN_B_DIRS_RESET;
      pat_b_len  <= PATTERN_B_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MOVE_THRESHOLD: thr_sq     <= thr_wr * thr_wr;
        CFG_PATTERN_A_DIRS: pat_a_dirs <= cfg_data[PATTERN_W-1:0];
        CFG_PATTERN_A_LEN:  pat_a_len  <= cfg_data[PAT_LEN_W-1:0];
        CFG_PATTERN_B_DIRS: pat_b_dirs <= cfg_data[PATTERN_W-1:0];
        CFG_PATTERN_B_LEN:  pat_b_len  <= cfg_data[PAT_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The compute stage moves only when the result register is free or drains.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_touch <= touching;
      s1_x     <= pos_x;
      s1_y     <= pos_y;
    end
  end

  always_comb begin
    dx      = $signed({1'b0, s1_x}) - $signed({1'b0, anchor_x});
    dy      = $signed({1'b0, s1_y}) - $signed({1'b0, anchor_y});
    ax      = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay      = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    sq_x    = ax * ax;
    sq_y    = ay * ay;
    dist_sq = DW'(sq_x) + DW'(sq_y);
    moved   = dist_sq >= DW'(thr_sq);
    if (ax > ay) begin
      new_dir = (!dx[COORD_BITS] && (dx != '0)) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      new_dir = (!dy[COORD_BITS] && (dy != '0)) ? DIR_DOWN : DIR_UP;
    end
    match_a = stroke_match(pat_a_dirs, pat_a_len, dir_store, dir_count, dir_overflow);
    match_b = stroke_match(pat_b_dirs, pat_b_len, dir_store, dir_count, dir_overflow);
  end

  always_comb begin
    anchor_valid_next = anchor_valid;
    anchor_load       = 1'b0;
    dir_store_write   = 1'b0;
    dir_count_next    = dir_count;
    dir_overflow_next = dir_overflow;
    found_reg_next    = found_reg;
    index_reg_next    = index_reg;
    priority if (!s1_touch) begin
      found_reg_next    = match_a || match_b;
      index_reg_next    = !match_a && match_b;
      dir_count_next    = '0;
      dir_overflow_next = 1'b0;
      anchor_valid_next = 1'b0;
    end else if (!anchor_valid) begin
      anchor_load       = 1'b1;
      anchor_valid_next = 1'b1;
    end else if (moved) begin
      anchor_load = 1'b1;
      if ((dir_count == '0) || (last_dir != new_dir)) begin
        if (dir_count < CW'(MAX_DIRS)) begin
          dir_store_write = 1'b1;
          dir_count_next  = dir_count + 1'b1;
        end else begin
          dir_overflow_next = 1'b1;
        end
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_valid <= 1'b0;
      dir_count    <= '0;
      dir_overflow <= 1'b0;
      found_reg    <= 1'b0;
      index_reg    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        anchor_valid <= anchor_valid_next;
        dir_count    <= dir_count_next;
        dir_overflow <= dir_overflow_next;
        found_reg    <= found_reg_next;
        index_reg    <= index_reg_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && anchor_load) begin
      anchor_x <= s1_x;
      anchor_y <= s1_y;
    end
    if (advance && dir_store_write) begin
      dir_store[dir_count[IW-1:0]] <= new_dir;
      last_dir                     <= new_dir;
    end
  end

  assign gesture_found = found_reg;
  assign gesture_index = index_reg;
  assign stroke_length = STROKE_W'(dir_count);

  `SGR_ASSERT_SAME(a_overflow_full, clk, rst, dir_overflow, dir_count == CW'(MAX_DIRS))
  `SGR_ASSERT_SAME(a_index_needs_found, clk, rst, index_reg, found_reg)
  `SGR_ASSERT_SAME(a_stall_needs_held_sample, clk, rst, in_stall, s1_valid)
  `SGR_ASSERT_NEXT(a_release_clears, clk, rst, advance && !s1_touch,
                   (dir_count == '0) && !dir_overflow && !anchor_valid && out_valid)

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgr_pkg::*;

  localparam int STROKE_DEPTH = 8;
  localparam int COORD_W = 12;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_SAMPLES = 200;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic found;
    logic index;
    logic [STROKE_W-1:0] length;
  } gesture_status_t;

  class stroke_scoreboard;
    logic [THRESHOLD_W-1:0] threshold;
    logic [PATTERN_W-1:0] pattern_dirs [2];
    logic [PAT_LEN_W-1:0] pattern_len [2];
    int anchor_x;
    int anchor_y;
    bit anchored;
    logic [1:0] stroke_dirs [STROKE_DEPTH];
    int stroke_count;
    bit stroke_overflow;
    gesture_status_t status;
    gesture_status_t expected_status [$];
    int errors;

    function new();
      threshold = MOVE_THRESHOLD_RESET;
      pattern_dirs[0] = PATTERN_A_DIRS_RESET;
      pattern_len[0] = PATTERN_A_LEN_RESET;
      pattern_dirs[1] = PATTERN_B_DIRS_RESET;
      pattern_len[1] = PATTERN_B_LEN_RESET;
      anchor_x = 0;
      anchor_y = 0;
      anchored = 1'b0;
      stroke_count = 0;
      stroke_overflow = 1'b0;
      status = '0;
      errors = 0;
    endfunction

    function void set_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MOVE_THRESHOLD: threshold = value[THRESHOLD_W-1:0];
        CFG_PATTERN_A_DIRS: pattern_dirs[0] = value[PATTERN_W-1:0];
        CFG_PATTERN_A_LEN: pattern_len[0] = value[PAT_LEN_W-1:0];
        CFG_PATTERN_B_DIRS: pattern_dirs[1] = value[PATTERN_W-1:0];
        CFG_PATTERN_B_LEN: pattern_len[1] = value[PAT_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function bit pattern_matches(int which);
      int i;
      if (stroke_overflow || int'(pattern_len[which]) != stroke_count ||
          pattern_len[which] > PATTERN_MAX) begin
        return 1'b0;
      end
      for (i = 0; i < int'(pattern_len[which]); i++) begin
        if (pattern_dirs[which][2*i +: 2] != stroke_dirs[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_sample(bit touch, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int dx;
      int dy;
      int mag_x;
      int mag_y;
      logic [1:0] heading;
      if (!touch) begin
        if (pattern_matches(0)) begin
          status.found = 1'b1;
          status.index = 1'b0;
        end else if (pattern_matches(1)) begin
          status.found = 1'b1;
          status.index = 1'b1;
        end else begin
          status.found = 1'b0;
          status.index = 1'b0;
        end
        stroke_count = 0;
        stroke_overflow = 1'b0;
        anchored = 1'b0;
      end else if (!anchored) begin
        anchor_x = int'(x);
        anchor_y = int'(y);
        anchored = 1'b1;
      end else begin
        dx = int'(x) - anchor_x;
        dy = int'(y) - anchor_y;
        if (dx * dx + dy * dy >= int'(threshold) * int'(threshold)) begin
          mag_x = (dx < 0) ? -dx : dx;
          mag_y = (dy < 0) ? -dy : dy;
          if (mag_x > mag_y) heading = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
          else heading = (dy > 0) ? DIR_DOWN : DIR_UP;
          if (stroke_count == 0 || stroke_dirs[stroke_count-1] != heading) begin
            if (stroke_count < STROKE_DEPTH) begin
              stroke_dirs[stroke_count] = heading;
              stroke_count++;
            end else begin
              stroke_overflow = 1'b1;
            end
          end
          anchor_x = int'(x);
          anchor_y = int'(y);
        end
      end
      status.length = STROKE_W'(stroke_count);
      expected_status = {expected_status, status};
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic found, logic index, logic [STROKE_W-1:0] length);
      gesture_status_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("result transfer with nothing expected (found=%0b index=%0b len=%0d)",
                         found, index, length));
        return;
      end
      want = expected_status.pop_front();
      if (found !== want.found)
        report($sformatf("gesture_found %0b, expected %0b", found, want.found));
      if (index !== want.index)
        report($sformatf("gesture_index %0b, expected %0b", index, want.index));
      if (length !== want.length)
        report($sformatf("stroke_length %0d, expected %0d", length, want.length));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MOVE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic touching = 1'b0;
  logic [COORD_W-1:0] pos_x = '0;
  logic [COORD_W-1:0] pos_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic gesture_found;
  logic gesture_index;
  logic [STROKE_W-1:0] stroke_length;

  stroke_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;
  int cur_x = 0;
  int cur_y = 0;
  int cur_thr = 10;
  logic [PATTERN_W-1:0] cur_pat [2];
  int cur_len [2];

  swipe_gesture_recognizer_top #(
    .MAX_DIRS(STROKE_DEPTH),
    .COORD_BITS(COORD_W)
  ) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(gesture_found, gesture_index, stroke_length);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic logic [PATTERN_W-1:0] make_pattern();
    logic [PATTERN_W-1:0] p;
    int i;
    p = PATTERN_W'($urandom);
    for (i = 1; i < PATTERN_W / 2; i++) begin
      if (p[2*i +: 2] == p[2*i-2 +: 2]) p[2*i +: 2] = p[2*i +: 2] + 2'd1;
    end
    return p;
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 10;
        recv_idle_pct <= 54;
      end
      1: begin
        send_idle_pct = 54;
        recv_idle_pct <= 10;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  task automatic send_sample(bit touch, int x, int y);
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    sx = COORD_W'(clamp_coord(x));
    sy = COORD_W'(clamp_coord(y));
    in_valid <= 1'b1;
    touching <= touch;
    pos_x <= sx;
    pos_y <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(touch, sx, sy);
    samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic swipe(logic [1:0] heading);
    int reach;
    int drift;
    int half;
    int nx;
    int ny;
    reach = cur_thr + int'($urandom_range(0, 24));
    drift = (reach > 0) ? int'($urandom_range(0, reach - 1)) : 0;
    if ($urandom_range(1)) drift = -drift;
    half = cur_thr / 2;
    // A small wobble stays below the threshold and must leave the anchor alone.
    if (half > 0 && $urandom_range(3) == 0) begin
      send_sample(1'b1, cur_x + int'($urandom_range(0, 2 * half)) - half,
                  cur_y + int'($urandom_range(0, 2 * half)) - half);
    end
    nx = cur_x;
    ny = cur_y;
    case (heading)
      DIR_RIGHT: begin
        nx = cur_x + reach;
        ny = cur_y + drift;
      end
      DIR_LEFT: begin
        nx = cur_x - reach;
        ny = cur_y + drift;
      end
      DIR_DOWN: begin
        nx = cur_x + drift;
        ny = cur_y + reach;
      end
      default: begin
        nx = cur_x + drift;
        ny = cur_y - reach;
      end
    endcase
    send_sample(1'b1, nx, ny);
    cur_x = clamp_coord(nx);
    cur_y = clamp_coord(ny);
  endtask

  task automatic draw_stroke(logic [31:0] path, int steps);
    int i;
    cur_x = $urandom_range(1200, 2900);
    cur_y = $urandom_range(1200, 2900);
    send_sample(1'b1, cur_x, cur_y);
    for (i = 0; i < steps; i++) begin
      swipe(path[2*i +: 2]);
      if ($urandom_range(4) == 0) swipe(path[2*i +: 2]);
    end
    send_sample(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  task automatic random_stroke();
    int pick;
    int which;
    int steps;
    int k;
    logic [31:0] path;
    pick = $urandom_range(99);
    if (pick >= 95) begin
      steps = $urandom_range(1, 6);
      for (k = 0; k < steps; k++) begin
        send_sample($urandom_range(99) < 70, $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX));
      end
    end else if (pick >= 75) begin
      draw_stroke($urandom, $urandom_range(0, 12));
    end else begin
      if (pick < 35) which = 0;
      else if (pick < 65) which = 1;
      else which = $urandom_range(1);
      path = {16'h0, cur_pat[which]};
      steps = (cur_len[which] > STROKE_DEPTH) ? STROKE_DEPTH : cur_len[which];
      if (pick >= 65) begin
        steps = steps + int'($urandom_range(0, 2)) - 1;
        if (steps < 0) steps = 0;
        if ($urandom_range(1)) begin
          k = $urandom_range(0, STROKE_DEPTH - 1);
          path[2*k +: 2] = 2'($urandom);
        end
      end
      draw_stroke(path, steps);
    end
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_config(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(int thr, logic [PATTERN_W-1:0] dirs_a, int len_a,
                           logic [PATTERN_W-1:0] dirs_b, int len_b);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(CFG_MOVE_THRESHOLD, CFG_DATA_W'(thr));
    write_register(CFG_PATTERN_A_DIRS, dirs_a);
    write_register(CFG_PATTERN_A_LEN, CFG_DATA_W'(len_a));
    write_register(CFG_PATTERN_B_DIRS, dirs_b);
    write_register(CFG_PATTERN_B_LEN, CFG_DATA_W'(len_b));
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_thr = thr;
    cur_pat[0] = dirs_a;
    cur_len[0] = len_a;
    cur_pat[1] = dirs_b;
    cur_len[1] = len_b;
  endtask

  initial begin
    int phase;
    int phase_start;
    int step;
    int thr;
    int len_a;
    int len_b;
    logic [PATTERN_W-1:0] dirs_a;
    logic [PATTERN_W-1:0] dirs_b;
    sb = new();
    set_idling(0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_sample(1'b0, 0, 0);
    send_sample(1'b1, COORD_MAX, COORD_MAX);
    send_sample(1'b1, 0, COORD_MAX);
    send_sample(1'b1, COORD_MAX, COORD_MAX);
    send_sample(1'b0, COORD_MAX, 0);
    send_sample(1'b1, 0, 0);
    send_sample(1'b1, COORD_MAX, 0);
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 0, COORD_MAX);
    send_sample(1'b1, 100, 100);
    send_sample(1'b1, 103, 104);
    send_sample(1'b1, 110, 110);
    send_sample(1'b1, 100, 100);
    send_sample(1'b1, 110, 100);
    send_sample(1'b0, 2048, 2048);

    // With a zero threshold and an empty first pattern, a bare release matches
    // and nine alternating moves run past the end of the stroke buffer.
    configure(0, PATTERN_A_DIRS_RESET, 0, 16'h1111, STROKE_DEPTH);
    send_sample(1'b0, 0, 0);
    send_sample(1'b1, 5, 5);
    for (step = 0; step < 9; step++) send_sample(1'b1, 5, 5 + step % 2);
    send_sample(1'b0, COORD_MAX, COORD_MAX);

    for (phase = 0; phase < 6; phase++) begin
      dirs_a = make_pattern();
      dirs_b = make_pattern();
      case (phase)
        0: begin
          thr = 10;
          len_a = $urandom_range(1, 4);
          len_b = $urandom_range(1, 4);
        end
        1: begin
          thr = 0;
          dirs_a = '0;
          len_a = 1;
          dirs_b = '1;
          len_b = STROKE_DEPTH;
        end
        2: begin
          thr = COORD_MAX;
          len_a = 0;
          len_b = 9;
        end
        3: begin
          thr = $urandom_range(1, 60);
          len_a = $urandom_range(1, 8);
          len_b = $urandom_range(1, 8);
        end
        4: begin
          thr = $urandom_range(1, 60);
          len_a = 15;
          len_b = $urandom_range(1, 8);
        end
        default: begin
          thr = $urandom_range(0, 30);
          len_a = $urandom_range(2, 6);
          len_b = $urandom_range(2, 6);
        end
      endcase
      configure(thr, dirs_a, len_a, dirs_b, len_b);
      set_idling(phase / 2);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_SAMPLES) begin
        random_stroke();
        if (phase == 4 && holds_asked == 0 && samples_sent - phase_start > 40) begin
          holds_asked <= 1;
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* swipe_gesture_recognizer_top.f */
+incdir+rtl
rtl/sgr_pkg.sv
rtl/swipe_gesture_recognizer_top.sv
tb/tb.sv
